// ----- rtl/core/interval_digit_group_parser_macros.svh -----
// Assertion macros shared by the parser RTL.
`ifndef INTERVAL_DIGIT_GROUP_PARSER_MACROS_SVH
`define INTERVAL_DIGIT_GROUP_PARSER_MACROS_SVH

// Check in the same cycle.
`define IDGP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check in the next cycle.
`define IDGP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/idgp_pkg.sv -----
package idgp_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MICRO_MODE  = 2'd1;

  localparam logic [2:0] FIELD_COUNT_RST = 3'd5;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [2:0] MICRO_DIGITS = 3'd6;
  localparam logic [2:0] DIGITS_SAT   = 3'd7;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_GROUP,
    PH_BETWEEN,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic close_step;
    logic emit;
  } idgp_cmd_t;

  typedef struct packed {
    logic close_req;
    logic eos_in;
    logic eos_held;
    logic scale_need;
    logic out_free;
    logic emit_last;
  } idgp_sts_t;

endpackage

// ----- rtl/core/idgp_ctrl.sv -----
module idgp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  idgp_pkg::idgp_sts_t sts,
  output idgp_pkg::idgp_cmd_t cmd
);

  idgp_pkg::ctl_state_t state_r;
  idgp_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= idgp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      idgp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (sts.close_req) begin
            state_nxt = idgp_pkg::ST_CLOSE;
          end else if (sts.eos_in) begin
            state_nxt = idgp_pkg::ST_EMIT;
          end
        end
      end
      idgp_pkg::ST_CLOSE: begin
        if (!sts.scale_need) begin
          state_nxt = sts.eos_held ? idgp_pkg::ST_EMIT : idgp_pkg::ST_IDLE;
        end
      end
      idgp_pkg::ST_EMIT: begin
        if (sts.out_free && sts.emit_last) begin
          state_nxt = idgp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = idgp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    cmd.accept     = 1'b0;
    cmd.close_step = 1'b0;
    cmd.emit       = 1'b0;
    unique case (state_r)
      idgp_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      idgp_pkg::ST_CLOSE: begin
        cmd.close_step = 1'b1;
      end
      idgp_pkg::ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/idgp_datapath.sv -----
module idgp_datapath #(
  parameter int MAX_FIELDS = 5,
  parameter int GW = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [GW-1:0]       field_cnt,
  input  logic                micro_mode,
  input  logic [7:0]          char_code,
  input  logic                no_char,
  input  logic                end_of_string,
  input  idgp_pkg::idgp_cmd_t cmd,
  output idgp_pkg::idgp_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_field_index,
  output logic [63:0]         out_field_value,
  output logic                out_bad_format,
  output logic                out_last_field
);

  localparam int KW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int XW = GW + 1;

  idgp_pkg::phase_t phase_r, phase_nxt, phase_chr;
  logic [63:0]      acc_r, acc_nxt;
  logic [2:0]       digits_r, digits_nxt;
  logic [GW-1:0]    grp_r, grp_nxt;
  logic             err_r, err_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             eos_r, at_end_r;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      pv_r [MAX_FIELDS];

  logic [2:0]       oidx_r;
  logic [63:0]      oval_r;
  logic             obad_r, olast_r;

  logic             has_char, is_dig, char_close;
  logic [63:0]      mul10, digit_ext;
  logic             last_grp, pv_we;
  logic [XW-1:0]    off, kx, diff;
  logic             aligned, rd_sel;
  logic [KW-1:0]    rd_idx;
  logic [63:0]      rd_val;

  assign has_char  = !no_char;
  assign is_dig    = has_char && (char_code >= idgp_pkg::ASCII_ZERO)
                     && (char_code <= idgp_pkg::ASCII_NINE);
  assign digit_ext = {60'd0, char_code[3:0]};
  assign mul10     = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0};
  assign char_close = has_char && !is_dig && (phase_r == idgp_pkg::PH_GROUP);

  assign last_grp = (XW'(grp_r) + XW'(1)) == XW'(field_cnt);
  assign sts.scale_need = micro_mode && (last_grp || at_end_r)
                          && (digits_r < idgp_pkg::MICRO_DIGITS);
  assign sts.eos_in   = end_of_string;
  assign sts.eos_held = eos_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign kx  = XW'(k_r);
  assign off = XW'(field_cnt) - XW'(grp_r);
  assign diff = kx - off;
  assign sts.emit_last = (kx + XW'(1)) == XW'(field_cnt);
  assign aligned = (phase_r == idgp_pkg::PH_DONE) || (grp_r >= field_cnt);

  always_comb begin
    rd_idx = k_r;
    rd_sel = 1'b1;
    if (!aligned) begin
      if (kx >= off) begin
        rd_idx = diff[KW-1:0];
      end else begin
        rd_sel = 1'b0;
      end
    end
  end

  assign rd_val = rd_sel ? pv_r[rd_idx] : 64'd0;

  // phase after the character alone; a closing group still reads as open
  always_comb begin
    phase_chr = phase_r;
    case (phase_r)
      idgp_pkg::PH_LEAD: if (is_dig) phase_chr = idgp_pkg::PH_GROUP;
      idgp_pkg::PH_BETWEEN: begin
        if (is_dig) begin
          phase_chr = (grp_r >= field_cnt) ? idgp_pkg::PH_DONE : idgp_pkg::PH_GROUP;
        end
      end
      default: phase_chr = phase_r;
    endcase
  end

  assign sts.close_req = (phase_chr == idgp_pkg::PH_GROUP) && (char_close || end_of_string);

  always_comb begin
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    digits_nxt    = digits_r;
    grp_nxt       = grp_r;
    err_nxt       = err_r;
    k_nxt         = k_r;
    pv_we         = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.accept) begin
      phase_nxt = phase_chr;
      case (phase_r)
        idgp_pkg::PH_LEAD: begin
          if (is_dig) begin
            grp_nxt    = '0;
            acc_nxt    = digit_ext;
            digits_nxt = 3'd1;
          end
        end
        idgp_pkg::PH_GROUP: begin
          if (is_dig) begin
            acc_nxt = mul10 + digit_ext;
            if (digits_r < idgp_pkg::DIGITS_SAT) begin
              digits_nxt = digits_r + 3'd1;
            end
          end
        end
        idgp_pkg::PH_BETWEEN: begin
          if (is_dig) begin
            if (grp_r >= field_cnt) begin
              err_nxt = 1'b1;
            end else begin
              acc_nxt    = digit_ext;
              digits_nxt = 3'd1;
            end
          end
        end
        default: begin
          if (is_dig) err_nxt = 1'b1;
        end
      endcase
    end else if (cmd.close_step) begin
      if (sts.scale_need) begin
        acc_nxt    = mul10;
        digits_nxt = digits_r + 3'd1;
      end else begin
        pv_we      = grp_r < field_cnt;
        grp_nxt    = grp_r + GW'(1);
        acc_nxt    = '0;
        digits_nxt = '0;
        phase_nxt  = last_grp || (grp_r >= field_cnt) ? idgp_pkg::PH_DONE
                                                      : idgp_pkg::PH_BETWEEN;
      end
    end else if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (sts.emit_last) begin
        k_nxt      = '0;
        grp_nxt    = '0;
        acc_nxt    = '0;
        digits_nxt = '0;
        err_nxt    = 1'b0;
        phase_nxt  = idgp_pkg::PH_LEAD;
      end else begin
        k_nxt = k_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= idgp_pkg::PH_LEAD;
      acc_r       <= '0;
      digits_r    <= '0;
      grp_r       <= '0;
      err_r       <= 1'b0;
      k_r         <= '0;
      eos_r       <= 1'b0;
      at_end_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      digits_r    <= digits_nxt;
      grp_r       <= grp_nxt;
      err_r       <= err_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.accept) begin
        eos_r    <= end_of_string;
        at_end_r <= !char_close;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_FIELDS; i++) begin
        pv_r[i] <= '0;
      end
    end else if (cmd.emit && sts.emit_last) begin
      for (int i = 0; i < MAX_FIELDS; i++) begin
        pv_r[i] <= '0;
      end
    end else if (pv_we) begin
      pv_r[grp_r[KW-1:0]] <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      oidx_r  <= 3'(k_r);
      oval_r  <= rd_val;
      obad_r  <= err_r;
      olast_r <= sts.emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_field_index = oidx_r;
  assign out_field_value = oval_r;
  assign out_bad_format  = obad_r;
  assign out_last_field  = olast_r;

endmodule

// ----- rtl/core/interval_digit_group_parser.sv -----
// One character word per cycle when idle; a character that ends a group adds a close
// step; in micro mode the final group is multiplied by ten until it has six digits.
// At end of string: close step if a group is open, then one result word per cycle while
// the output is free, field_count words; first word shows in the cycle after its load.
// Synchronous active-low reset clears the parser and sets field_count 5, micro_mode 0.
`include "interval_digit_group_parser_macros.svh"

module interval_digit_group_parser #(
  parameter int MAX_FIELDS = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,  // char_code
  input  logic                           in_tuser,  // no_char
  input  logic                           in_tlast,  // end_of_string
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [71:0]                    out_tdata, // field_index, field_value, zero pad
  output logic                           out_tuser, // bad_format
  output logic                           out_tlast, // last_field
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [idgp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [idgp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int GW = $clog2(MAX_FIELDS + 1);

  logic [2:0]          field_count_r;
  logic                micro_mode_r;
  logic [GW-1:0]       field_cnt;
  idgp_pkg::idgp_cmd_t cmd;
  idgp_pkg::idgp_sts_t sts;
  logic [2:0]          fidx;
  logic [63:0]         fval;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_count_r <= idgp_pkg::FIELD_COUNT_RST;
      micro_mode_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        idgp_pkg::CFG_FIELD_COUNT: field_count_r <= cfg_data;
        idgp_pkg::CFG_MICRO_MODE:  micro_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (field_count_r == 3'd0) begin
      field_cnt = GW'(1);
    end else if (32'(field_count_r) > MAX_FIELDS) begin
      field_cnt = GW'(MAX_FIELDS);
    end else begin
      field_cnt = GW'(field_count_r);
    end
  end

  idgp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  idgp_datapath #(
    .MAX_FIELDS (MAX_FIELDS),
    .GW         (GW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .field_cnt       (field_cnt),
    .micro_mode      (micro_mode_r),
    .char_code       (in_tdata),
    .no_char         (in_tuser),
    .end_of_string   (in_tlast),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_field_index (fidx),
    .out_field_value (fval),
    .out_bad_format  (out_tuser),
    .out_last_field  (out_tlast)
  );

  assign out_tdata = {5'd0, fval, fidx};

  `IDGP_ASSERT_NXT(a_eos_blocks_input, in_tvalid && in_tready && in_tlast, !in_tready, "input taken during result run")
  `IDGP_ASSERT_NOW(a_last_index, out_tvalid && out_tlast, out_tdata[2:0] == 3'(field_cnt - GW'(1)), "last word index mismatch")
  `IDGP_ASSERT_NXT(a_run_continues, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tdata[2:0] == 3'($past(out_tdata[2:0]) + 3'd1)), "result run broken")

endmodule
